/* src/wcm_pkg.sv */
// ----------------------------------------------------------------------------
// wcm_pkg
// shared types and constants for the wavetable channel mixer
// ----------------------------------------------------------------------------
package wcm_pkg;

    localparam int POS_W        = 30;
    localparam int FRAC_BITS    = 12;
    localparam int OFFSET_SHIFT = 20;
    localparam int WORD_SHIFT   = 13;
    localparam int OUT_SHIFT    = 8;

    // remainder unit operand widths
    localparam int REM_DVD_W = 19;
    localparam int REM_DVS_W = 21;

    typedef enum logic [2:0] {
        ACT_LOAD   = 3'd0,
        ACT_START  = 3'd1,
        ACT_VOLUME = 3'd2,
        ACT_INCR   = 3'd3,
        ACT_MIX    = 3'd4
    } action_t;

    typedef struct packed {
        logic                 start;
        logic [REM_DVD_W-1:0] dividend;
        logic [REM_DVS_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic                 done;
        logic [REM_DVS_W-1:0] remainder;
    } rem_rsp_t;

endpackage

/* src/wcm_rem.sv */
// ----------------------------------------------------------------------------
// wcm_rem
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module wcm_rem
    import wcm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  rem_req_t req,
    output rem_rsp_t rsp
);

    localparam int CNT_W = $clog2(REM_DVD_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [REM_DVD_W-1:0] dvd_reg;
    logic [REM_DVS_W-1:0] dvs_reg;
    logic [REM_DVS_W-1:0] rem_reg;
    logic [REM_DVS_W:0]   trial;
    logic [REM_DVS_W:0]   diff;
    logic [REM_DVS_W-1:0] rem_next;

    assign trial = {rem_reg, dvd_reg[REM_DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = diff[REM_DVS_W-1:0];
        end else begin
            rem_next = trial[REM_DVS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !req.start && busy_reg && (cnt_reg == CNT_W'(REM_DVD_W - 1));
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[REM_DVD_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(REM_DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* src/wavetable_channel_mixer.sv */
// ----------------------------------------------------------------------------
// wavetable_channel_mixer
// multi-channel sample playback mixer with internal sample memory
// ----------------------------------------------------------------------------
// start, volume and increment items complete in idle; a load writes its byte in
// load_wr; a mix visits scan, read, mult and accum for each active channel and
// scan only for each idle channel, and waits in emit while the previous result
// item has not been taken
// each loop wrap waits on the shared remainder unit in wrap_wait, and so does each
// address reduction (in addr_wait) when SAMPLE_MEM_BYTES is not a power of two
// reset clears active flags, increments and volumes; sample memory is not cleared and needs no pass
module wavetable_channel_mixer
    import wcm_pkg::*;
#(
    parameter int NUM_CHANNELS     = 4,
    parameter int SAMPLE_MEM_BYTES = 131072
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // channel, mem_address, byte_value, start_offset, length_words,
    // loop_start_words, loop_length_words, volume_level, step_increment
    input  logic [111:0] s_tdata,
    // action
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // sample_out, active_mask
    output logic [15:0]  m_tdata
);

    localparam int  CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int  AW       = $clog2(SAMPLE_MEM_BYTES);
    localparam bit  MEM_POW2 = (SAMPLE_MEM_BYTES & (SAMPLE_MEM_BYTES - 1)) == 0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR_WAIT,
        ST_LOAD_WR,
        ST_SCAN,
        ST_READ,
        ST_MULT,
        ST_ACCUM,
        ST_WRAP_WAIT,
        ST_EMIT
    } state_t;

    // input fields
    action_t     in_action;
    logic [1:0]  in_channel;
    logic [16:0] in_addr;
    logic [7:0]  in_byte;
    logic [7:0]  in_offset;
    logic [15:0] in_len;
    logic [15:0] in_lstart;
    logic [15:0] in_llen;
    logic [6:0]  in_volume;
    logic [19:0] in_incr;

    assign in_action  = action_t'(s_tuser);
    assign in_channel = s_tdata[1:0];
    assign in_addr    = s_tdata[18:2];
    assign in_byte    = s_tdata[26:19];
    assign in_offset  = s_tdata[34:27];
    assign in_len     = s_tdata[50:35];
    assign in_lstart  = s_tdata[66:51];
    assign in_llen    = s_tdata[82:67];
    assign in_volume  = s_tdata[89:83];
    assign in_incr    = s_tdata[109:90];

    state_t              state_reg;
    action_t             act_reg;
    logic [CH_W-1:0]     ch_idx_reg;
    logic [15:0]         sum_reg;
    logic signed [15:0]  prod_reg;
    logic [AW-1:0]       addr_reg;
    logic [7:0]          byte_reg;
    logic [7:0]          rd_data_reg;
    logic [12:0]         excess_lo_reg;
    logic [POS_W-1:0]    wrap_base_reg;
    logic                m_tvalid_reg;
    logic [15:0]         m_tdata_reg;
    logic                rem_start_reg;
    logic [REM_DVD_W-1:0] rem_dvd_reg;
    logic [REM_DVS_W-1:0] rem_dvs_reg;

    logic              active_reg [NUM_CHANNELS];
    logic [16:0]       base_reg   [NUM_CHANNELS];
    logic [POS_W-1:0]  pos_reg    [NUM_CHANNELS];
    logic [19:0]       inc_reg    [NUM_CHANNELS];
    logic [6:0]        vol_reg    [NUM_CHANNELS];
    logic [16:0]       end_reg    [NUM_CHANNELS];
    logic [15:0]       llen_reg   [NUM_CHANNELS];

    logic [7:0] sample_mem [SAMPLE_MEM_BYTES];

    rem_req_t rem_req;
    rem_rsp_t rem_rsp;

    logic                 in_accept;
    logic                 ch_ok;
    logic [5:0]           in_ch_ext;
    logic [CH_W-1:0]      in_ch;
    logic [REM_DVS_W-1:0] load_ext;
    logic [REM_DVD_W-1:0] addr_sum;
    logic [REM_DVS_W-1:0] addr_ext;
    logic [POS_W:0]       pos_sum;
    logic [POS_W:0]       end_ext;
    logic                 at_end;
    logic [POS_W:0]       excess;
    logic [POS_W-1:0]     wrap_base;
    logic [POS_W-1:0]     end_b;
    logic                 last_ch;
    logic [3:0]           mask;
    logic [16:0]          start_end;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_ch_ext = {4'b0, in_channel};
    assign in_ch     = in_ch_ext[CH_W-1:0];
    assign ch_ok     = (32'(in_channel) < NUM_CHANNELS);
    assign load_ext  = {4'b0, in_addr};
    assign start_end = (in_llen != 16'd0) ? ({1'b0, in_lstart} + {1'b0, in_llen})
                                          : {1'b0, in_len};

    assign addr_sum  = {2'b0, base_reg[ch_idx_reg]}
                     + {1'b0, pos_reg[ch_idx_reg][POS_W-1:FRAC_BITS]};
    assign addr_ext  = {2'b0, addr_sum};

    assign end_b     = {end_reg[ch_idx_reg], 13'b0};
    assign pos_sum   = {1'b0, pos_reg[ch_idx_reg]} + {11'b0, inc_reg[ch_idx_reg]};
    assign end_ext   = {1'b0, end_b};
    assign at_end    = (pos_sum >= end_ext);
    assign excess    = pos_sum - end_ext;
    assign wrap_base = end_b - {1'b0, llen_reg[ch_idx_reg], 13'b0};
    assign last_ch   = (ch_idx_reg == CH_W'(NUM_CHANNELS - 1));

    genvar gi;
    generate
        for (gi = 0; gi < 4; gi++) begin : g_mask
            if (gi < NUM_CHANNELS) begin : g_on
                assign mask[gi] = active_reg[gi];
            end else begin : g_off
                assign mask[gi] = 1'b0;
            end
        end
    endgenerate

    assign rem_req.start    = rem_start_reg;
    assign rem_req.dividend = rem_dvd_reg;
    assign rem_req.divisor  = rem_dvs_reg;

    wcm_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .rsp     (rem_rsp)
    );

    // sample memory
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD_WR) begin
            sample_mem[addr_reg] <= byte_reg;
        end
        rd_data_reg <= sample_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            act_reg       <= ACT_LOAD;
            ch_idx_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
            rem_start_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                active_reg[c] <= 1'b0;
                inc_reg[c]    <= '0;
                vol_reg[c]    <= '0;
            end
        end else begin
            rem_start_reg <= (!MEM_POW2 && in_accept && (in_action == ACT_LOAD))
                          || (!MEM_POW2 && (state_reg == ST_SCAN) && active_reg[ch_idx_reg])
                          || ((state_reg == ST_ACCUM) && at_end
                              && (llen_reg[ch_idx_reg] != 16'd0));
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        act_reg <= in_action;
                        case (in_action)
                            ACT_LOAD: begin
                                byte_reg <= in_byte;
                                if (MEM_POW2) begin
                                    addr_reg  <= load_ext[AW-1:0];
                                    state_reg <= ST_LOAD_WR;
                                end else begin
                                    rem_dvd_reg   <= {2'b0, in_addr};
                                    rem_dvs_reg   <= REM_DVS_W'(SAMPLE_MEM_BYTES);
                                    state_reg     <= ST_ADDR_WAIT;
                                end
                            end
                            ACT_START: begin
                                if (ch_ok) begin
                                    active_reg[in_ch] <= 1'b1;
                                    base_reg[in_ch]   <= in_addr;
                                    pos_reg[in_ch]    <= POS_W'(in_offset) << OFFSET_SHIFT;
                                    end_reg[in_ch]    <= start_end;
                                    llen_reg[in_ch]   <= in_llen;
                                end
                            end
                            ACT_VOLUME: begin
                                if (ch_ok) begin
                                    vol_reg[in_ch] <= in_volume;
                                end
                            end
                            ACT_INCR: begin
                                if (ch_ok) begin
                                    inc_reg[in_ch] <= in_incr;
                                end
                            end
                            ACT_MIX: begin
                                ch_idx_reg <= '0;
                                sum_reg    <= '0;
                                state_reg  <= ST_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_ADDR_WAIT: begin
                    if (rem_rsp.done) begin
                        addr_reg  <= rem_rsp.remainder[AW-1:0];
                        state_reg <= (act_reg == ACT_LOAD) ? ST_LOAD_WR : ST_READ;
                    end
                end
                ST_LOAD_WR: begin
                    state_reg <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (active_reg[ch_idx_reg]) begin
                        if (MEM_POW2) begin
                            addr_reg  <= addr_ext[AW-1:0];
                            state_reg <= ST_READ;
                        end else begin
                            rem_dvd_reg   <= addr_sum;
                            rem_dvs_reg   <= REM_DVS_W'(SAMPLE_MEM_BYTES);
                            state_reg     <= ST_ADDR_WAIT;
                        end
                    end else if (last_ch) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        ch_idx_reg <= ch_idx_reg + 1'b1;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_MULT;
                end
                ST_MULT: begin
                    prod_reg  <= $signed(rd_data_reg) * $signed({1'b0, vol_reg[ch_idx_reg]});
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM: begin
                    sum_reg <= sum_reg + prod_reg;
                    if (at_end && (llen_reg[ch_idx_reg] != 16'd0)) begin
                        excess_lo_reg <= excess[WORD_SHIFT-1:0];
                        wrap_base_reg <= wrap_base;
                        rem_dvd_reg   <= {1'b0, excess[POS_W:WORD_SHIFT]};
                        rem_dvs_reg   <= {5'b0, llen_reg[ch_idx_reg]};
                        state_reg     <= ST_WRAP_WAIT;
                    end else begin
                        pos_reg[ch_idx_reg] <= pos_sum[POS_W-1:0];
                        if (at_end) begin
                            active_reg[ch_idx_reg] <= 1'b0;
                        end
                        if (last_ch) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            ch_idx_reg <= ch_idx_reg + 1'b1;
                            state_reg  <= ST_SCAN;
                        end
                    end
                end
                ST_WRAP_WAIT: begin
                    if (rem_rsp.done) begin
                        pos_reg[ch_idx_reg] <= wrap_base_reg
                                             + {1'b0, rem_rsp.remainder[15:0], excess_lo_reg};
                        if (last_ch) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            ch_idx_reg <= ch_idx_reg + 1'b1;
                            state_reg  <= ST_SCAN;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'b0, mask, sum_reg[15:OUT_SHIFT]};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_out_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_EMIT)
        else $error("result raised outside emit");

    a_rem_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_rsp.done |-> (state_reg == ST_ADDR_WAIT || state_reg == ST_WRAP_WAIT))
        else $error("remainder finished with no one waiting");

    a_mix_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_action == ACT_MIX) |=> !s_tready)
        else $error("ready during mix");
`endif

endmodule
